// ----- sv/saltag_pkg.sv -----
// Package for the set-associative LRU tag store.
// Holds defaults, field widths, register indexes, item codes and the
// command type that passes from the controller to the datapath.
package saltag_pkg;

    // Default geometry
    localparam int DEF_SETS     = 256;
    localparam int DEF_WAYS     = 4;
    localparam int DEF_TAG_BITS = 20;

    // Item field widths
    localparam int SET_IDX_W = 8;
    localparam int LINE_TAG_W = 20;
    localparam int COUNT_W   = 11;
    localparam int WAYS_CFG_W = 3;

    // Flush count ceiling
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    // Configuration register indexes
    localparam logic REG_WAYS_IN_USE = 1'b0;
    localparam logic REG_WRITE_BACK  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [WAYS_CFG_W-1:0] RST_WAYS_IN_USE = 3'd4;
    localparam logic                  RST_WRITE_BACK  = 1'b1;

    // Item function codes
    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // Controller commands
    typedef struct packed {
        logic load;    // item taken: start set read, capture fields
        logic commit;  // write set back on an access, load the result register
    } ctl_cmd_t;

endpackage

// ----- sv/saltag_ctrl.sv -----
// Controller for the set-associative LRU tag store.
// Two-state sequencer over item accept and result commit; uses saltag_pkg.
module saltag_ctrl
    import saltag_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output ctl_cmd_t cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Checks
    a_load_idle : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load outside idle");
    a_load_next : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_LOOKUP)
        else $error("no lookup after load");
    a_commit_out : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result lost after commit");
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten");

endmodule

// ----- sv/saltag_dp.sv -----
// Datapath for the set-associative LRU tag store: set memory, per-set
// init flags, per-way dirty counters, lookup and update logic, result register.
// Uses saltag_pkg.
module saltag_dp
    import saltag_pkg::*;
#(
    parameter int SETS     = DEF_SETS,
    parameter int WAYS     = DEF_WAYS,
    parameter int TAG_BITS = DEF_TAG_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_cmd_t              cmd,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [WAYS_CFG_W-1:0] cfg_data,
    input  logic                  in_func,
    input  logic [SET_IDX_W-1:0]  in_set_index,
    input  logic [LINE_TAG_W-1:0] in_line_tag,
    input  logic                  in_is_write,
    output logic                  hit,
    output logic                  evicted_dirty,
    output logic                  filled_empty,
    output logic [COUNT_W-1:0]    dirty_count
);

    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W    = $clog2(WAYS + 1);
    localparam int CNT_W   = $clog2(SETS + 1);
    localparam int SUM_W   = $clog2(SETS * WAYS + 1);
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(WAYS - 1);

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                valid;
        logic                dirty;
        logic [RANK_W-1:0]   rank;
    } line_t;

    // Set index modulo SETS by restoring subtraction
    function automatic logic [SET_W-1:0] wrap_set(input logic [SET_IDX_W-1:0] idx);
        logic [SET_IDX_W:0] r;
        r = {1'b0, idx};
        for (int k = SET_IDX_W - 1; k >= 0; k--)
        begin
            if ((SETS << k) <= 255 && int'(r) >= (SETS << k))
            begin
                r = r - (SET_IDX_W + 1)'(SETS << k);
            end
        end
        return SET_W'(r);
    endfunction

    line_t [WAYS-1:0]    mem [SETS];
    line_t [WAYS-1:0]    rd_row_reg;
    logic                rd_init_reg;
    logic [SETS-1:0]     set_init_reg;
    logic [CNT_W-1:0]    dirty_cnt_reg [WAYS];

    logic                func_reg;
    logic [SET_W-1:0]    set_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                wr_reg;

    logic [WAYS_CFG_W-1:0] ways_cfg_reg;
    logic                  wb_mode_reg;

    logic                hit_reg, evict_reg, fill_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [SET_W-1:0]    set_in;
    logic [NW_W-1:0]     n_use;
    logic [WAYS-1:0]     in_use;
    line_t [WAYS-1:0]    cur, nxt;
    logic                found, free_found;
    logic [WAY_W-1:0]    hit_way, free_way, vic_way, tgt;
    logic [RANK_W-1:0]   best, limit;
    logic                lim_all;
    logic                old_d, new_d;
    logic                evict_c;
    logic [SUM_W-1:0]    sum;
    logic [COUNT_W-1:0]  count_c;

    assign set_in = wrap_set(in_set_index);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_cfg_reg <= RST_WAYS_IN_USE;
            wb_mode_reg  <= RST_WRITE_BACK;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAYS_IN_USE: ways_cfg_reg <= cfg_data;
                REG_WRITE_BACK:  wb_mode_reg  <= cfg_data[0];
                default:         ways_cfg_reg <= ways_cfg_reg;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            set_reg  <= set_in;
            tag_reg  <= TAG_BITS'(in_line_tag);
            wr_reg   <= in_is_write;
        end
    end

    // Set memory: registered read on load, write back on an access commit
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_row_reg <= mem[set_in];
        end
        if (cmd.commit && func_reg == FUNC_ACCESS)
        begin
            mem[set_reg] <= nxt;
        end
    end

    // Per-set written flags; an unwritten set reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_init_reg <= '0;
            rd_init_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_init_reg <= set_init_reg[set_in];
            end
            if (cmd.commit && func_reg == FUNC_ACCESS)
            begin
                set_init_reg[set_reg] <= 1'b1;
            end
        end
    end

    // Lookup, victim choice and row update
    always_comb
    begin
        if (ways_cfg_reg == '0)
            n_use = NW_W'(1);
        else if (int'(ways_cfg_reg) > WAYS)
            n_use = NW_W'(WAYS);
        else
            n_use = NW_W'(ways_cfg_reg);

        cur = rd_init_reg ? rd_row_reg : '0;

        found      = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            in_use[w] = (w < int'(n_use));
            if (in_use[w] && cur[w].valid && cur[w].tag == tag_reg)
            begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (in_use[w] && !cur[w].valid)
            begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end

        // Highest rank wins, lowest way on a tie
        best    = '0;
        vic_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (in_use[w] && cur[w].rank > best)
            begin
                best    = cur[w].rank;
                vic_way = WAY_W'(w);
            end
        end

        priority if (found)
            tgt = hit_way;
        else if (free_found)
            tgt = free_way;
        else
            tgt = vic_way;

        lim_all = !found;
        limit   = cur[tgt].rank;
        evict_c = !found && !free_found && cur[tgt].dirty;

        // Age newer valid ways in use (all on a miss); target made most recent
        nxt = cur;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) != tgt && in_use[w] && cur[w].valid &&
                (lim_all || cur[w].rank < limit) && cur[w].rank != RANK_TOP)
            begin
                nxt[w].rank = cur[w].rank + RANK_W'(1);
            end
        end
        nxt[tgt].rank = '0;
        if (!found)
        begin
            nxt[tgt].tag   = tag_reg;
            nxt[tgt].valid = 1'b1;
            nxt[tgt].dirty = 1'b0;
        end
        if (wr_reg)
        begin
            nxt[tgt].dirty = wb_mode_reg;
        end

        old_d = cur[tgt].valid && cur[tgt].dirty;
        new_d = nxt[tgt].valid && nxt[tgt].dirty;
    end

    // Flush count from the per-way dirty counters
    always_comb
    begin
        sum = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (w < int'(n_use))
            begin
                sum = sum + SUM_W'(dirty_cnt_reg[w]);
            end
        end
        if (SUM_W > COUNT_W && sum > SUM_W'(COUNT_MAX))
            count_c = COUNT_MAX;
        else
            count_c = COUNT_W'(sum);
    end

    // Dirty line counters, one per way
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                dirty_cnt_reg[w] <= '0;
            end
        end
        else if (cmd.commit && func_reg == FUNC_ACCESS)
        begin
            if (new_d && !old_d)
                dirty_cnt_reg[tgt] <= dirty_cnt_reg[tgt] + CNT_W'(1);
            else if (old_d && !new_d)
                dirty_cnt_reg[tgt] <= dirty_cnt_reg[tgt] - CNT_W'(1);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (func_reg == FUNC_FLUSH)
            begin
                hit_reg   <= 1'b0;
                evict_reg <= 1'b0;
                fill_reg  <= 1'b0;
                count_reg <= count_c;
            end
            else
            begin
                hit_reg   <= found;
                evict_reg <= evict_c;
                fill_reg  <= !found && free_found;
                count_reg <= '0;
            end
        end
    end

    assign hit           = hit_reg;
    assign evicted_dirty = evict_reg;
    assign filled_empty  = fill_reg;
    assign dirty_count   = count_reg;

    a_hit_fill : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && func_reg == FUNC_ACCESS |-> !(found && free_found && hit_way == free_way))
        else $error("hit on a free way");

endmodule

// ----- sv/set_assoc_lru_tag_store_core.sv -----
// Set-associative LRU tag store, top level.
// Joins saltag_ctrl and saltag_dp; uses saltag_pkg.
//
// Usage:
//   Slave channel s_*: one item per access or flush. s_tuser is the function
//   (0 access, 1 flush count). Master channel m_*: one result per item.
//   cfg_we/cfg_index/cfg_data write ways_in_use (index 0) or
//   write_back_mode (index 1); write only while no item is in flight.
//   Each item is handled in order: the set row is read from the set memory,
//   then the ways are compared, the row is written back on an access and the
//   result register and m_tvalid are loaded; this waits while an earlier result
//   is held. s_tready is low from taking an item until its result is loaded.
//   A flush reads running per-way dirty counters and goes through the same steps.
//   Reset clears all lines to invalid through per-set flags, at once; no
//   clearing pass. If m_tready stays low, the result is held and the block
//   stops taking items after the one that follows it.
module set_assoc_lru_tag_store_core
    import saltag_pkg::*;
#(
    parameter int SETS     = DEF_SETS,
    parameter int WAYS     = DEF_WAYS,
    parameter int TAG_BITS = DEF_TAG_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // set_index[7:0], line_tag[27:8], is_write[28], zero fill
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // hit[0], evicted_dirty[1], filled_empty[2],
                                   // dirty_count[13:3], zero fill
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data
);

    ctl_cmd_t           cmd;
    logic               hit, evicted_dirty, filled_empty;
    logic [COUNT_W-1:0] dirty_count;

    saltag_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    saltag_dp #(
        .SETS     (SETS),
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_func       (s_tuser),
        .in_set_index  (s_tdata[7:0]),
        .in_line_tag   (s_tdata[27:8]),
        .in_is_write   (s_tdata[28]),
        .hit           (hit),
        .evicted_dirty (evicted_dirty),
        .filled_empty  (filled_empty),
        .dirty_count   (dirty_count)
    );

    assign m_tdata = {2'b00, dirty_count, filled_empty, evicted_dirty, hit};

endmodule
